// ===== sv/rational_arith_unit_macros.svh =====
// ----------------------------------------------------------------------------
// rational_arith_unit_macros
// Concurrent assertion macros used by the rational arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define RAU_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define RAU_ASSERT(label, clk, rst_n, prop)
`define RAU_ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== sv/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared constants and types of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
  localparam int WIDTH = 32;
  localparam int DW    = 2 * WIDTH;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_CHECK,
    ST_MOD,
    ST_MODSTEP,
    ST_DIVN,
    ST_DIVD,
    ST_QSTEP,
    ST_LIMIT,
    ST_OUT
  } state_t;

  // what the shared divider is computing
  typedef enum logic [1:0] {
    PH_MOD,
    PH_NUM,
    PH_DEN
  } phase_t;
endpackage
`default_nettype wire

// ===== sv/rational_arith_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit
// Exact add, subtract, multiply and divide of two fractions, reduced by GCD.
// ----------------------------------------------------------------------------
// Usage: present the command and the two fractions on in_* with in_valid;
// the beat is taken at an edge where in_valid and in_ready are high. The
// unit then works alone: one shared 32x32 multiplier forms the cross
// products and the raw denominator (one product per cycle), and one shared
// restoring divider, one quotient bit per cycle, runs Euclid and then the
// two reducing divisions.
// When the raw numerator or denominator is zero, the unit skips the divider
// and goes straight to the result. Otherwise each Euclid remainder takes a
// setup state (MOD), a full division (MODSTEP) and a swap state (QSTEP);
// then the two reducing divisions (DIVN, DIVD) and the range check (LIMIT)
// follow.
// in_ready is low from acceptance until the result beat leaves; the next
// beat can be taken from the cycle after that, so one item runs at a time.
// The result is held on out_* with out_valid until out_ready; a stalled
// receiver holds the unit. Reset (rst_n low, synchronous) empties it:
// in_ready high, out_valid low. Divide by zero and overflow give 0/1.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rational_arith_unit_macros.svh"
module rational_arith_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_command,
  input  wire logic signed [31:0]  in_a_num,
  input  wire logic [30:0]         in_a_den,
  input  wire logic signed [31:0]  in_b_num,
  input  wire logic [30:0]         in_b_den,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       out_res_num,
  output logic [30:0]              out_res_den,
  output logic                     out_div_by_zero,
  output logic                     out_overflow
);
  localparam int W  = rau_pkg::WIDTH;
  localparam int DW = rau_pkg::DW;
  localparam int CW = $clog2(DW);
  localparam logic [DW-1:0] LIM_POS = DW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [DW-1:0] LIM_NEG = DW'(64'd1 << (W - 1));

  rau_pkg::state_t state_r, state_nxt;

  // operands: numerators taken to WIDTH bits, denominators to WIDTH-1 bits
  logic signed [W-1:0] an_r, bn_r;
  logic [W-2:0]        ad_r, bd_r;
  rau_pkg::cmd_t       cmd_r;

  // shared multiplier operands and registered product
  logic signed [W-1:0]    ma, mb;
  logic signed [2*W-1:0]  prod_r;
  logic signed [DW-1:0]   p1_r, rn_r;

  // Euclid / divider registers
  logic [DW-1:0] nm_r, dm_r;          // magnitudes
  logic [DW-1:0] x_r, y_r;            // Euclid pair
  logic [DW-1:0] dvd_r, dvs_r, rem_r, quo_r;
  logic [CW-1:0] cnt_r;
  logic          neg_r;
  rau_pkg::phase_t phase_r;
  logic signed [31:0] res_num_r;
  logic [30:0]  res_den_r;
  logic         dz_r, ov_r;

  logic [DW:0]  rem_sh;
  logic         fits;

  assign in_ready  = (state_r == rau_pkg::ST_IDLE);
  assign out_valid = (state_r == rau_pkg::ST_OUT);
  assign out_res_num = res_num_r;
  assign out_res_den = res_den_r;
  assign out_div_by_zero = dz_r;
  assign out_overflow = ov_r;

  // multiplier operand selection: one product per cycle
  always_comb begin
    ma = an_r;
    mb = $signed({1'b0, bd_r});
    case (state_r)
      rau_pkg::ST_MUL1: begin
        ma = an_r;
        mb = (cmd_r == rau_pkg::CMD_MUL) ? bn_r : $signed({1'b0, bd_r});
      end
      rau_pkg::ST_MUL2: begin
        ma = bn_r;
        mb = $signed({1'b0, ad_r});
      end
      rau_pkg::ST_SUM: begin
        ma = $signed({1'b0, ad_r});
        mb = (cmd_r == rau_pkg::CMD_DIV) ? bn_r : $signed({1'b0, bd_r});
      end
      default: begin
        ma = an_r;
        mb = bn_r;
      end
    endcase
  end

  // one restoring divide step
  assign rem_sh = {rem_r, dvd_r[DW-1]};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rau_pkg::ST_IDLE:    if (in_valid) state_nxt = rau_pkg::ST_MUL1;
      rau_pkg::ST_MUL1:    state_nxt = rau_pkg::ST_MUL2;
      rau_pkg::ST_MUL2:    state_nxt = rau_pkg::ST_SUM;
      rau_pkg::ST_SUM:     state_nxt = rau_pkg::ST_CHECK;
      rau_pkg::ST_CHECK: begin
        // prod_r holds the raw denominator here
        if (prod_r == '0 || rn_r == '0) state_nxt = rau_pkg::ST_OUT;
        else state_nxt = rau_pkg::ST_MOD;
      end
      rau_pkg::ST_MOD:     state_nxt = rau_pkg::ST_MODSTEP;
      rau_pkg::ST_MODSTEP: begin
        if (cnt_r == CW'(DW - 1)) begin
          case (phase_r)
            rau_pkg::PH_MOD: state_nxt = rau_pkg::ST_QSTEP;
            rau_pkg::PH_NUM: state_nxt = rau_pkg::ST_DIVD;
            default:         state_nxt = rau_pkg::ST_LIMIT;
          endcase
        end
      end
      rau_pkg::ST_QSTEP: begin
        if (rem_r == '0) state_nxt = rau_pkg::ST_DIVN;
        else state_nxt = rau_pkg::ST_MOD;
      end
      rau_pkg::ST_DIVN:    state_nxt = rau_pkg::ST_MODSTEP;
      rau_pkg::ST_DIVD:    state_nxt = rau_pkg::ST_MODSTEP;
      rau_pkg::ST_LIMIT:   state_nxt = rau_pkg::ST_OUT;
      rau_pkg::ST_OUT:     if (out_ready) state_nxt = rau_pkg::ST_IDLE;
      default:             state_nxt = rau_pkg::ST_IDLE;
    endcase
  end

  // reduced result fits in range: quo_r is the reduced denominator and
  // nm_r the reduced numerator magnitude while in LIMIT
  always_comb begin
    fits = (quo_r <= LIM_POS) &&
           (neg_r ? (nm_r <= LIM_NEG) : (nm_r <= LIM_POS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rau_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    case (state_r)
      rau_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_r <= rau_pkg::cmd_t'(in_command);
          an_r  <= in_a_num[W-1:0];
          bn_r  <= in_b_num[W-1:0];
          ad_r  <= in_a_den[W-2:0];
          bd_r  <= in_b_den[W-2:0];
        end
      end
      rau_pkg::ST_MUL2:  p1_r <= DW'(prod_r);
      rau_pkg::ST_SUM: begin
        // prod_r holds the second cross product here
        case (cmd_r)
          rau_pkg::CMD_ADD: rn_r <= p1_r + DW'(prod_r);
          rau_pkg::CMD_SUB: rn_r <= p1_r - DW'(prod_r);
          default:          rn_r <= p1_r;
        endcase
      end
      default: ;
    endcase

    case (state_r)
      rau_pkg::ST_CHECK: begin
        dz_r <= (prod_r == '0);
        ov_r <= 1'b0;
        res_num_r <= '0;
        res_den_r <= 31'd1;
        neg_r <= rn_r[DW-1] ^ prod_r[2*W-1];
        nm_r  <= rn_r[DW-1] ? (DW'(0) - rn_r) : rn_r;
        dm_r  <= prod_r[2*W-1] ? (DW'(0) - DW'(prod_r)) : DW'(prod_r);
        x_r   <= rn_r[DW-1] ? (DW'(0) - rn_r) : rn_r;
        y_r   <= prod_r[2*W-1] ? (DW'(0) - DW'(prod_r)) : DW'(prod_r);
        phase_r <= rau_pkg::PH_MOD;
      end
      rau_pkg::ST_MOD: begin
        dvd_r <= x_r;
        dvs_r <= y_r;
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= '0;
      end
      rau_pkg::ST_MODSTEP: begin
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r + CW'(1);
        if (rem_sh >= {1'b0, dvs_r}) begin
          rem_r <= DW'(rem_sh - {1'b0, dvs_r});
          quo_r <= {quo_r[DW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[DW-1:0];
          quo_r <= {quo_r[DW-2:0], 1'b0};
        end
      end
      rau_pkg::ST_QSTEP: begin
        x_r <= y_r;
        y_r <= rem_r;
      end
      rau_pkg::ST_DIVN: begin
        // x_r holds the gcd once the remainder hit zero
        phase_r <= rau_pkg::PH_NUM;
        dvd_r <= nm_r;
        dvs_r <= x_r;
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= '0;
      end
      rau_pkg::ST_DIVD: begin
        phase_r <= rau_pkg::PH_DEN;
        nm_r  <= quo_r;
        dvd_r <= dm_r;
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= '0;
      end
      rau_pkg::ST_LIMIT: begin
        if (!fits) begin
          ov_r <= 1'b1;
        end else begin
          res_num_r <= 32'(neg_r ? (DW'(0) - nm_r) : nm_r);
          res_den_r <= 31'(quo_r);
        end
      end
      default: ;
    endcase
  end

  `RAU_ASSERT(a_ready_out_excl, clk, rst_n, !(in_ready && out_valid))
  `RAU_ASSERT(a_out_flags, clk, rst_n, out_valid |-> !(out_div_by_zero && out_overflow))
  `RAU_ASSERT(a_err_zero, clk, rst_n,
    (out_valid && (out_div_by_zero || out_overflow)) |-> (out_res_num == 0 && out_res_den == 1))
  `RAU_ASSERT(a_den_pos, clk, rst_n, out_valid |-> (out_res_den != 0))
  `RAU_ASSERT(a_out_hold, clk, rst_n,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_res_num) && $stable(out_res_den)))
endmodule
`default_nettype wire

// ===== verif/rational_arith_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arith_unit_tb
// Self-checking bench for the fraction add/sub/mul/div unit with GCD reduce.
// Operand beats go in over a valid/ready channel and result beats come back
// over another. A behavioral model in this file predicts each reduced
// fraction and its flags, and a checker compares every result beat against
// the oldest pending prediction. Directed corner cases come first, then
// random traffic under three idling patterns.
// ----------------------------------------------------------------------------
`default_nettype none
module rational_arith_unit_tb;

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               dz;
    logic               ov;
  } fraction_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_command = rau_pkg::CMD_ADD;
  logic signed [31:0] in_a_num = '0;
  logic [30:0]        in_a_den = 31'd1;
  logic signed [31:0] in_b_num = '0;
  logic [30:0]        in_b_den = 31'd1;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_res_num;
  logic [30:0]        out_res_den;
  logic               out_div_by_zero;
  logic               out_overflow;

  // Idle percentages of the two sides.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  fraction_t   pending_q[$];
  int unsigned error_count = 0;
  int unsigned beats_checked = 0;

  always #1 clk = ~clk;

  rational_arith_unit dut (.*);

  // Compute the reduced fraction of one command exactly.
  function automatic fraction_t reduce_fraction(logic [1:0] cmd, logic signed [31:0] an,
                                                logic [30:0] ad, logic signed [31:0] bn,
                                                logic [30:0] bd);
    fraction_t        r;
    logic signed [63:0] rn, rd, sad, sbd;
    logic [63:0]      nm, dm, x, y, t;
    logic             neg;
    sad = {33'd0, ad};
    sbd = {33'd0, bd};
    r.num = '0; r.den = 31'd1; r.dz = 1'b0; r.ov = 1'b0;
    case (cmd)
      rau_pkg::CMD_ADD: begin rn = an * sbd + bn * sad; rd = sad * sbd; end
      rau_pkg::CMD_SUB: begin rn = an * sbd - bn * sad; rd = sad * sbd; end
      rau_pkg::CMD_MUL: begin rn = an * bn;             rd = sad * sbd; end
      default:          begin rn = an * sbd;            rd = sad * bn;  end
    endcase
    if (rd == 0) begin
      r.dz = 1'b1;
      return r;
    end
    if (rn == 0) return r;
    neg = (rn < 0) != (rd < 0);
    nm = (rn < 0) ? -rn : rn;
    dm = (rd < 0) ? -rd : rd;
    x = nm;
    y = dm;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    nm = nm / x;
    dm = dm / x;
    if (dm > 64'h7FFF_FFFF || (neg ? nm > 64'h8000_0000 : nm > 64'h7FFF_FFFF)) begin
      r.ov = 1'b1;
      return r;
    end
    r.num = neg ? -nm[31:0] : nm[31:0];
    r.den = dm[30:0];
    return r;
  endfunction

  // Drive one operand beat and hold it until the unit takes it.
  task automatic send_operands(logic [1:0] cmd, logic signed [31:0] an, logic [30:0] ad,
                               logic signed [31:0] bn, logic [30:0] bd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_a_num   <= an;
    in_a_den   <= ad;
    in_b_num   <= bn;
    in_b_den   <= bd;
    pending_q.push_back(reduce_fraction(cmd, an, ad, bn, bd));
    do @(posedge clk); while (!in_ready);
  endtask

  // Toggle the receiver's ready at random.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check each result beat against the oldest prediction.
  always @(posedge clk) begin
    fraction_t e;
    if (rst_n && out_valid && out_ready) begin
      beats_checked++;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing pending");
        error_count++;
      end else begin
        e = pending_q.pop_front();
        if (out_res_num !== e.num) begin
          $error("res_num expected %0d got %0d", e.num, out_res_num); error_count++;
        end
        if (out_res_den !== e.den) begin
          $error("res_den expected %0d got %0d", e.den, out_res_den); error_count++;
        end
        if (out_div_by_zero !== e.dz) begin
          $error("div_by_zero expected %0b got %0b", e.dz, out_div_by_zero); error_count++;
        end
        if (out_overflow !== e.ov) begin
          $error("overflow expected %0b got %0b", e.ov, out_overflow); error_count++;
        end
      end
    end
  end

  function automatic logic [30:0] rand_den();
    case ($urandom_range(3))
      0:       return 31'($urandom_range(1, 16));
      1:       return 31'($urandom_range(1, 65535));
      2:       return 31'h7FFF_FFFF - 31'($urandom_range(15));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_num();
    case ($urandom_range(4))
      0:       return 32'($urandom_range(0, 32)) - 32'sd16;
      1:       return 32'h8000_0000 + 32'($urandom_range(15));
      2:       return 32'h7FFF_FFFF - 32'($urandom_range(15));
      3:       return 32'($urandom_range(0, 131071)) - 32'sd65536;
      default: return $urandom;
    endcase
  endfunction

  // Corner operands across every command, including zero and bad denominators.
  task automatic test_directed();
    logic [1:0] c;
    for (int k = 0; k < 4; k++) begin
      c = k[1:0];
      send_operands(c, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, -32'sh8000_0000, 31'd1);
      send_operands(c, -32'sh8000_0000, 31'd1, -32'sh8000_0000, 31'd1);
      send_operands(c, 32'sd6, 31'd4, 32'sd0, 31'd9);
      send_operands(c, 32'sd3, 31'd0, 32'sd1, 31'd2);
      send_operands(c, -32'sd1, 31'd3, 32'sd1, 31'd3);
    end
    send_operands(rau_pkg::CMD_SUB, 32'sd5, 31'd7, 32'sd5, 31'd7);
    send_operands(rau_pkg::CMD_DIV, -32'sd1, 31'd2, 32'sh7FFF_FFFF, 31'h7FFF_FFFE);
    send_operands(rau_pkg::CMD_ADD, 32'hFFFF_FFFF, 31'h5555_5555, 32'h5555_5555,
                  31'h2AAA_AAAA);
  endtask

  // Random beats; occasionally zero denominators to hit the flag path.
  task automatic test_random(int unsigned count);
    logic [30:0] ad, bd;
    for (int unsigned i = 0; i < count; i++) begin
      ad = ($urandom_range(49) == 0) ? 31'd0 : rand_den();
      bd = ($urandom_range(49) == 0) ? 31'd0 : rand_den();
      send_operands(2'($urandom_range(3)), rand_num(), ad, rand_num(), bd);
    end
  endtask

  // Drop valid after the last beat and wait for every result.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle_pct = 33; recv_idle_pct = 53;
    test_random(400);
    send_idle_pct = 53; recv_idle_pct = 33;
    test_random(400);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(400);
    drain();
    $display("Covered all four commands with corner, zero and bad-denominator operands,");
    $display("%0d result beats checked under three idling patterns.", beats_checked);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Time limit for the whole run; on expiry report a failure and stop.
  initial begin
    #100_000_000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/rau_pkg.sv
sv/rational_arith_unit.sv
verif/rational_arith_unit_tb.sv
